// File: src/asmtok_pkg.sv
`timescale 1ns / 1ps

package asmtok_pkg;

  localparam int OFFSET_BITS       = 24;
  localparam int KEYWORD_MAX_CHARS = 4;
  localparam int PREFIX_BITS       = 8 * KEYWORD_MAX_CHARS;
  localparam int VALUE_BITS        = 64;
  localparam int KEYWORD_COUNT     = 15;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OFFSET_BITS-1:0] LEN_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_EOF     = 8'hff;

  typedef enum logic [2:0] {
    TK_END     = 3'd0,
    TK_OPCODE  = 3'd1,
    TK_REG     = 3'd2,
    TK_LITERAL = 3'd3,
    TK_IDENT   = 3'd4
  } token_kind_t;

  typedef enum logic [4:0] {
    MODE_SKIP    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_DEC     = 5'b00100,
    MODE_HEX     = 5'b01000,
    MODE_COMMENT = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    token_kind_t                   kind;
    logic [OFFSET_BITS-1:0]        start;
    logic [3:0]                    code;
    logic signed [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0]        length;
    logic                          last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_out_t;

  typedef struct packed {
    logic [QUEUE_CNT_BITS-1:0] level;
    logic                      room;
  } queue_status_t;

  typedef struct packed {
    logic [31:0] text;
    logic [2:0]  len;
    token_kind_t kind;
    logic [3:0]  code;
  } keyword_t;

  typedef struct packed {
    logic        hit;
    token_kind_t kind;
    logic [3:0]  code;
  } keyword_hit_t;

  localparam keyword_t KEYWORDS [KEYWORD_COUNT] = '{
    '{32'h68616c74, 3'd4, TK_OPCODE, 4'd0},  // halt
    '{32'h006d6f76, 3'd3, TK_OPCODE, 4'd1},  // mov
    '{32'h00616464, 3'd3, TK_OPCODE, 4'd2},  // add
    '{32'h00737562, 3'd3, TK_OPCODE, 4'd3},  // sub
    '{32'h00646976, 3'd3, TK_OPCODE, 4'd4},  // div
    '{32'h006d756c, 3'd3, TK_OPCODE, 4'd5},  // mul
    '{32'h74657374, 3'd4, TK_OPCODE, 4'd6},  // test
    '{32'h006a6e7a, 3'd3, TK_OPCODE, 4'd7},  // jnz
    '{32'h00006a7a, 3'd2, TK_OPCODE, 4'd8},  // jz
    '{32'h00726130, 3'd3, TK_REG,    4'd0},  // ra0
    '{32'h00726131, 3'd3, TK_REG,    4'd1},
    '{32'h00726132, 3'd3, TK_REG,    4'd2},
    '{32'h00726133, 3'd3, TK_REG,    4'd3},
    '{32'h00726134, 3'd3, TK_REG,    4'd4},
    '{32'h00726135, 3'd3, TK_REG,    4'd5}
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_dec(c) || is_alpha(c);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || is_hex_letter(c);
  endfunction

  // Letters a-f and A-F share their low nibble (1..6); non-hex bytes add nothing.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (is_dec(c)) v = c[3:0];
    else if (is_hex_letter(c)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic keyword_hit_t keyword_match(input logic [PREFIX_BITS-1:0] prefix,
                                                 input logic [OFFSET_BITS-1:0] len);
    keyword_hit_t r;
    r = '{hit: 1'b0, kind: TK_IDENT, code: 4'd0};
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      if (!r.hit && (len == OFFSET_BITS'(KEYWORDS[i].len)) &&
          (prefix == PREFIX_BITS'(KEYWORDS[i].text))) begin
        r.hit  = 1'b1;
        r.kind = KEYWORDS[i].kind;
        r.code = KEYWORDS[i].code;
      end
    end
    return r;
  endfunction

endpackage

// File: src/asmtok_scan.sv
`timescale 1ns / 1ps

module asmtok_scan import asmtok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] source_byte,
  input  logic       stream_end,
  output scan_out_t  result
);

  logic [7:0]                   held_byte, held_byte_next;
  logic                         held_valid, held_valid_next;
  scan_mode_t                   scan_mode, scan_mode_next;
  logic                         negative_flag, negative_flag_next;
  logic                         skip_next_byte, skip_next_byte_next;
  logic signed [VALUE_BITS-1:0] accum, accum_next;
  logic [OFFSET_BITS-1:0]       stream_position, stream_position_next;
  logic [OFFSET_BITS-1:0]       token_start, token_start_next;
  logic [OFFSET_BITS-1:0]       word_length, word_length_next;
  logic [PREFIX_BITS-1:0]       word_prefix, word_prefix_next;

  logic                         end_item;
  logic [7:0]                   peek;
  logic [OFFSET_BITS-1:0]       at;
  scan_mode_t                   work_mode;
  logic                         go;
  logic                         emit;
  token_t                       scan_tok;
  token_t                       end_tok;
  logic signed [VALUE_BITS-1:0] accum_x10;
  logic signed [VALUE_BITS-1:0] dec_value;
  logic signed [VALUE_BITS-1:0] hex_value;
  logic [OFFSET_BITS-1:0]       len_inc;
  logic [PREFIX_BITS-1:0]       prefix_inc;
  keyword_hit_t                 kw;

  assign end_item  = stream_end || (source_byte == CH_EOF);
  assign peek      = end_item ? CH_EOF : source_byte;
  assign at        = stream_position - OFFSET_BITS'(1);
  assign accum_x10 = (accum <<< 3) + (accum <<< 1);
  assign hex_value = (accum <<< 4) | VALUE_BITS'(hex_nibble(held_byte));
  assign len_inc   = (word_length < LEN_MAX) ? word_length + OFFSET_BITS'(1) : word_length;
  assign prefix_inc = (word_length < OFFSET_BITS'(KEYWORD_MAX_CHARS)) ?
                      {word_prefix[PREFIX_BITS-9:0], held_byte} : word_prefix;
  assign kw        = keyword_match(prefix_inc, len_inc);

  always_comb begin
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    scan_mode_next       = scan_mode;
    negative_flag_next   = negative_flag;
    skip_next_byte_next  = skip_next_byte;
    accum_next           = accum;
    stream_position_next = stream_position;
    token_start_next     = token_start;
    word_length_next     = word_length;
    word_prefix_next     = word_prefix;
    work_mode            = scan_mode;
    go                   = 1'b0;
    emit                 = 1'b0;
    scan_tok             = '0;
    scan_tok.start       = token_start;
    dec_value            = '0;

    // Judge the held byte against the incoming one as lookahead.
    if (held_valid) begin
      if (skip_next_byte) begin
        skip_next_byte_next = 1'b0;
      end else if (scan_mode == MODE_SKIP) begin
        token_start_next = at;
        if ((held_byte == CH_COMMA) || (held_byte == CH_SPACE) ||
            (held_byte == CH_NEWLINE)) begin
          go = 1'b0;
        end else if (held_byte == CH_SLASH) begin
          if (peek == CH_SLASH) scan_mode_next = MODE_COMMENT;
        end else if (held_byte == CH_MINUS) begin
          if (is_dec(peek)) begin
            scan_mode_next     = MODE_DEC;
            negative_flag_next = 1'b1;
          end
        end else if (is_dec(held_byte)) begin
          if (peek == CH_X) begin
            scan_mode_next      = MODE_HEX;
            skip_next_byte_next = 1'b1;
          end else begin
            work_mode          = MODE_DEC;
            negative_flag_next = 1'b0;
            go                 = 1'b1;
          end
        end else begin
          work_mode = MODE_IDENT;
          go        = 1'b1;
        end
      end else begin
        go = 1'b1;
      end
    end

    scan_tok.start = token_start_next;

    if (go) begin
      scan_mode_next = work_mode;
      unique case (work_mode)
        MODE_IDENT: begin
          word_prefix_next = prefix_inc;
          word_length_next = len_inc;
          if (!is_alnum(peek)) begin
            emit = 1'b1;
            if (kw.hit) begin
              scan_tok.kind = kw.kind;
              scan_tok.code = kw.code;
            end else begin
              scan_tok.kind   = TK_IDENT;
              scan_tok.length = len_inc;
            end
          end
        end
        MODE_DEC: begin
          // Keep the sign folded into the accumulator.
          dec_value  = negative_flag_next ?
                       accum_x10 - VALUE_BITS'(held_byte[3:0]) :
                       accum_x10 + VALUE_BITS'(held_byte[3:0]);
          accum_next = dec_value;
          if (!is_dec(peek)) begin
            emit           = 1'b1;
            scan_tok.kind  = TK_LITERAL;
            scan_tok.value = dec_value;
          end
        end
        MODE_HEX: begin
          accum_next = hex_value;
          if (!is_hex(peek)) begin
            emit           = 1'b1;
            scan_tok.kind  = TK_LITERAL;
            scan_tok.value = hex_value;
          end
        end
        default: begin
          if (held_byte == CH_NEWLINE) scan_mode_next = MODE_SKIP;
        end
      endcase
      if (emit) begin
        scan_mode_next     = MODE_SKIP;
        negative_flag_next = 1'b0;
        accum_next         = '0;
        word_length_next   = '0;
        word_prefix_next   = '0;
        token_start_next   = at + OFFSET_BITS'(1);
      end
    end

    end_tok       = '0;
    end_tok.kind  = TK_END;
    end_tok.start = token_start_next;
    end_tok.last  = 1'b1;

    scan_tok.last = !end_item;

    if (end_item) begin
      result.count  = emit ? 2'd2 : 2'd1;
      result.first  = emit ? scan_tok : end_tok;
      result.second = end_tok;
      held_byte_next       = '0;
      held_valid_next      = 1'b0;
      scan_mode_next       = MODE_SKIP;
      negative_flag_next   = 1'b0;
      skip_next_byte_next  = 1'b0;
      accum_next           = '0;
      stream_position_next = '0;
      token_start_next     = '0;
      word_length_next     = '0;
      word_prefix_next     = '0;
    end else begin
      result.count         = {1'b0, emit};
      result.first         = scan_tok;
      result.second        = end_tok;
      held_byte_next       = source_byte;
      held_valid_next      = 1'b1;
      stream_position_next = stream_position + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte       <= '0;
      held_valid      <= 1'b0;
      scan_mode       <= MODE_SKIP;
      negative_flag   <= 1'b0;
      skip_next_byte  <= 1'b0;
      accum           <= '0;
      stream_position <= '0;
      token_start     <= '0;
      word_length     <= '0;
      word_prefix     <= '0;
    end else if (fire) begin
      held_byte       <= held_byte_next;
      held_valid      <= held_valid_next;
      scan_mode       <= scan_mode_next;
      negative_flag   <= negative_flag_next;
      skip_next_byte  <= skip_next_byte_next;
      accum           <= accum_next;
      stream_position <= stream_position_next;
      token_start     <= token_start_next;
      word_length     <= word_length_next;
      word_prefix     <= word_prefix_next;
    end
  end

endmodule

// File: src/asmtok_queue.sv
`timescale 1ns / 1ps

module asmtok_queue import asmtok_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scan_out_t     push_data,
  input  logic          pop,
  output logic          head_valid,
  output token_t        head,
  output queue_status_t status
);

  token_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, wr_ptr_next;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] level, level_next;
  logic [QUEUE_CNT_BITS-1:0] push_count;
  logic                      pop_ok;

  assign push_count  = push ? QUEUE_CNT_BITS'(push_data.count) : '0;
  assign pop_ok      = pop && (level != '0);
  assign level_next  = level + push_count - QUEUE_CNT_BITS'(pop_ok);
  assign wr_ptr_next = wr_ptr + push_count[QUEUE_PTR_BITS-1:0];

  assign head_valid   = (level != '0);
  assign head         = slots[rd_ptr];
  assign status.level = level;
  assign status.room  = (level <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop_ok) rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (push_data.count != 2'd0)) slots[wr_ptr] <= push_data.first;
    if (push && (push_data.count == 2'd2)) slots[wr_ptr + QUEUE_PTR_BITS'(1)] <= push_data.second;
  end

endmodule

// File: src/assembly_source_tokenizer.sv
`timescale 1ns / 1ps

// Assembly source tokenizer. Takes one source byte per transfer and turns the stream into
// tokens (opcode words, register names, literals, identifiers, end). Each byte is judged
// against the byte after it, so a token comes out one transfer after its last byte
// arrives; an end transfer (stream_end, or byte 255) flushes the held byte and adds the
// end token, so it can yield two tokens. Rate is one byte per cycle while the queue has
// room: a byte passes an input register, the scanner updates its registered state, and
// tokens go into a four-entry output queue. Input stalls only while that queue has fewer
// than two free slots; an end transfer with two tokens hands them out one at a time.
module assembly_source_tokenizer import asmtok_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   source_byte,
  input  logic                         stream_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   token_kind,
  output logic [OFFSET_BITS-1:0]       start_offset,
  output logic [3:0]                   word_code,
  output logic signed [VALUE_BITS-1:0] literal_value,
  output logic [OFFSET_BITS-1:0]       ident_length,
  output logic                         last_of_run
);

  logic          item_valid;
  logic [7:0]    item_byte;
  logic          item_end;
  logic          fire;
  scan_out_t     scan_result;
  token_t        head;
  queue_status_t q_status;

  assign fire     = item_valid && q_status.room;
  assign in_ready = !item_valid || q_status.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= source_byte;
      item_end  <= stream_end;
    end
  end

  asmtok_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .source_byte (item_byte),
    .stream_end  (item_end),
    .result      (scan_result)
  );

  asmtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_data  (scan_result),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .status     (q_status)
  );

  assign token_kind    = head.kind;
  assign start_offset  = head.start;
  assign word_code     = head.code;
  assign literal_value = head.value;
  assign ident_length  = head.length;
  assign last_of_run   = head.last;

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    fire && (item_end || (item_byte == CH_EOF)) |-> scan_result.count != 2'd0)
    else $error("end item produced no token");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    fire && (scan_result.count == 2'd2) |->
      (scan_result.second.kind == TK_END) && !scan_result.first.last)
    else $error("token pair not closed by end token");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_run_last: assert property (@(posedge clk) disable iff (rst)
    fire && (scan_result.count == 2'd1) |-> scan_result.first.last)
    else $error("single token missing last flag");

endmodule
